// File: design/lrul_pkg.sv
// Shared types and constants for the LRU/MRU replacement list.
// Used by lrul_ctrl, lrul_dpath and lru_mru_replacement_list.
package lrul_pkg;

    localparam int FRAME_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int OPCODE_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACCESS = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ADDR_VICTIM_MODE = 2'd0;

    // controller -> datapath
    typedef struct packed {
        logic ready;      // idle, may take a word
        logic take;       // word accepted this cycle
        logic clr_step;   // clear one residency entry
        logic link_mid;   // first half of a move: bypass the frame's neighbors
        logic commit_b;   // final update of a one-step operation, load result
        logic commit_c;   // append after a bypass, load result
    } lrul_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // clearing pass at its last entry
        logic mid_access; // access of a frame with neighbors on both sides
        logic out_free;   // output register can take a result
    } lrul_sts_t;

endpackage

// File: design/lrul_ctrl.sv
// Sequencer for the replacement list: clearing pass, accept, update phases.
// Depends on lrul_pkg.
module lrul_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  lrul_pkg::lrul_sts_t sts,
    output lrul_pkg::lrul_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_APPEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.ready = 1'b1;
                cmd.take  = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (sts.mid_access) begin
                    cmd.link_mid = 1'b1;
                    state_next   = ST_APPEND;
                end else if (sts.out_free) begin
                    cmd.commit_b = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_APPEND: begin
                if (sts.out_free) begin
                    cmd.commit_c = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/lrul_dpath.sv
// Datapath of the replacement list: link and residency memories, head, tail,
// count and the result register. Depends on lrul_pkg; driven by lrul_ctrl.
module lrul_dpath #(
    parameter int FRAMES = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lrul_pkg::lrul_cmd_t                  cmd,
    output lrul_pkg::lrul_sts_t                  sts,
    input  logic                                 victim_mode,
    input  logic [lrul_pkg::OPCODE_W-1:0]        opcode_in,
    input  logic [lrul_pkg::FRAME_W-1:0]         frame_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lrul_pkg::FRAME_W-1:0]         out_victim,
    output logic                                 out_vvalid,
    output logic                                 out_error,
    output logic [lrul_pkg::COUNT_W-1:0]         out_count
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int XW = (IW > lrul_pkg::FRAME_W) ? IW : lrul_pkg::FRAME_W;

    logic [IW-1:0] next_mem [FRAMES];
    logic [IW-1:0] prev_mem [FRAMES];
    logic          res_mem  [FRAMES];

    logic [XW-1:0] frm_x;
    logic [IW-1:0] idx_in;
    logic          ok_in;

    logic [lrul_pkg::OPCODE_W-1:0] op_reg;
    logic [IW-1:0] fidx_reg;
    logic          fok_reg;
    logic [IW-1:0] nxt_q;
    logic [IW-1:0] prv_q;
    logic          res_q;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [IW-1:0] clr_reg;

    logic          ovalid_reg;
    logic [lrul_pkg::FRAME_W-1:0] ovictim_reg;
    logic          ovv_reg;
    logic          oerr_reg;
    logic [lrul_pkg::COUNT_W-1:0] ocnt_reg;

    logic is_head, is_tail, multi, empty;
    logic ins_ok, acc_ok, rem_ok, err;
    logic rem_mid, app_b, mid_we, app_we;
    logic          nx_we, pv_we, rs_we;
    logic [IW-1:0] nx_addr, nx_data, pv_addr, pv_data, rs_addr;
    logic          rs_data;
    logic          load_out;
    logic [IW-1:0] victim_idx;
    logic [31:0]   victim_32;
    logic [31:0]   count_32;

    assign frm_x  = XW'(frame_in);
    assign idx_in = frm_x[IW-1:0];
    assign ok_in  = {22'd0, frame_in} < 32'(FRAMES);

    assign is_head = fidx_reg == head_reg;
    assign is_tail = fidx_reg == tail_reg;
    assign multi   = cnt_reg > CW'(1);
    assign empty   = cnt_reg == '0;

    assign ins_ok = fok_reg && op_reg == lrul_pkg::OP_INSERT && !res_q;
    assign acc_ok = fok_reg && op_reg == lrul_pkg::OP_ACCESS && res_q;
    assign rem_ok = fok_reg && op_reg == lrul_pkg::OP_REMOVE && res_q;
    assign err    = !(ins_ok || acc_ok || rem_ok);

    assign rem_mid = rem_ok && multi && !is_head && !is_tail;
    assign app_b   = (ins_ok && !empty) || (acc_ok && multi && is_head);
    assign mid_we  = (cmd.commit_b && rem_mid) || cmd.link_mid;
    assign app_we  = (cmd.commit_b && app_b) || cmd.commit_c;

    assign sts.clr_last   = clr_reg == IW'(FRAMES - 1);
    assign sts.mid_access = acc_ok && multi && !is_head && !is_tail;
    assign sts.out_free   = !ovalid_reg || out_ready;

    // bypass: next[p] = n, prev[n] = p; append: next[tail] = f, prev[f] = tail
    assign nx_we   = mid_we || app_we;
    assign nx_addr = mid_we ? prv_q : tail_reg;
    assign nx_data = mid_we ? nxt_q : fidx_reg;
    assign pv_we   = mid_we || app_we;
    assign pv_addr = mid_we ? nxt_q : fidx_reg;
    assign pv_data = mid_we ? prv_q : tail_reg;

    assign rs_we   = cmd.clr_step || (cmd.commit_b && (ins_ok || rem_ok));
    assign rs_addr = cmd.clr_step ? clr_reg : fidx_reg;
    assign rs_data = !cmd.clr_step && ins_ok;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (cmd.commit_b) begin
            if (ins_ok) begin
                if (empty) begin
                    head_next = fidx_reg;
                end
                tail_next = fidx_reg;
                cnt_next  = cnt_reg + CW'(1);
            end else if (rem_ok) begin
                if (!multi) begin
                    head_next = '0;
                    tail_next = '0;
                end else if (is_head) begin
                    head_next = nxt_q;
                end else if (is_tail) begin
                    tail_next = prv_q;
                end
                cnt_next = cnt_reg - CW'(1);
            end else if (acc_ok && multi && is_head) begin
                head_next = nxt_q;
                tail_next = fidx_reg;
            end
        end else if (cmd.commit_c) begin
            tail_next = fidx_reg;
        end
    end

    assign load_out   = cmd.commit_b || cmd.commit_c;
    assign victim_idx = (cnt_next == '0) ? '0 : (victim_mode ? tail_next : head_next);
    assign victim_32  = 32'(victim_idx);
    assign count_32   = 32'(cnt_next);

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_addr] <= nx_data;
        end
        if (pv_we) begin
            prev_mem[pv_addr] <= pv_data;
        end
        if (rs_we) begin
            res_mem[rs_addr] <= rs_data;
        end
        if (cmd.take) begin
            nxt_q    <= next_mem[idx_in];
            prv_q    <= prev_mem[idx_in];
            res_q    <= res_mem[idx_in];
            op_reg   <= opcode_in;
            fidx_reg <= idx_in;
            fok_reg  <= ok_in;
        end
        if (load_out) begin
            ovictim_reg <= victim_32[lrul_pkg::FRAME_W-1:0];
            ovv_reg     <= cnt_next != '0;
            oerr_reg    <= err;
            ocnt_reg    <= count_32[lrul_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (load_out) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_victim = ovictim_reg;
    assign out_vvalid = ovv_reg;
    assign out_error  = oerr_reg;
    assign out_count  = ocnt_reg;

endmodule

// File: design/lru_mru_replacement_list.sv
// Top level of the LRU/MRU replacement list: stream ports, APB register.
// Depends on lrul_pkg, lrul_ctrl and lrul_dpath.
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser opcode, s_tdata frame
// m_        out  m_tvalid/m_tready  m_tuser valid/error, m_tdata victim/count
// apb       in   psel/penable       victim_mode at address 0
//
// A word passes an accept and an update state; an access of a frame with
// neighbors on both sides adds an append state, set by the single write port of
// each link memory. After reset the residency memory is swept with s_tready low.
// The result register frees the input: a new word is taken while the last
// result waits, and the next result holds its update until m_tready drains it.
module lru_mru_replacement_list #(
    parameter int FRAMES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] frame, [15:10] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] victim_frame, [20:10] resident_count
    output logic [1:0]  m_tuser,   // [0] victim_valid, [1] op_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lrul_pkg::lrul_cmd_t cmd;
    lrul_pkg::lrul_sts_t sts;

    logic                           mode_reg;
    logic [lrul_pkg::FRAME_W-1:0]   victim;
    logic                           vvalid;
    logic                           op_err;
    logic [lrul_pkg::COUNT_W-1:0]   count;

    assign pready = 1'b1;
    assign prdata = {31'd0, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr == lrul_pkg::ADDR_VICTIM_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    lrul_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrul_dpath #(
        .FRAMES (FRAMES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .victim_mode (mode_reg),
        .opcode_in   (s_tuser),
        .frame_in    (s_tdata[9:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_victim  (victim),
        .out_vvalid  (vvalid),
        .out_error   (op_err),
        .out_count   (count)
    );

    assign s_tready = cmd.ready;
    assign m_tdata  = {3'd0, count, victim};
    assign m_tuser  = {op_err, vvalid};

endmodule
